// ----- rtl/core/gcr62_sector_data_decoder_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 6-and-2 sector data decoder
// ----------------------------------------------------------------------------
`ifndef GCR62_SECTOR_DATA_DECODER_UNIT_MACROS_SVH
`define GCR62_SECTOR_DATA_DECODER_UNIT_MACROS_SVH

// Consequent checked in the cycle after the antecedent, masked during reset.
`define GCR62_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Consequent checked in the same cycle, masked during reset.
`define GCR62_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the next cycle, reset not masked.
`define GCR62_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/gcr62_sdd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcr62_sdd_pkg
// Types, constants and the 6-and-2 translation for the sector data decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr62_sdd_pkg;

   localparam int RemainderCount   = 86;
   localparam int ChecksumPosition = 342;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef enum logic {
      KIND_DATA   = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   result_kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      status_type status_code;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } xlate_type;

   localparam logic [7:0] GcrTable [64] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

   // Table entries are distinct, so at most one compare hits.
   function automatic xlate_type gcr_translate(input logic [7:0] b);
      xlate_type r;
      r.valid = 1'b0;
      r.value = 6'd0;
      for (int k = 0; k < 64; k++) begin
         if (GcrTable[k] == b) begin
            r.valid = 1'b1;
            r.value = 6'(k);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gcr62_sdd_if.sv -----
// ----------------------------------------------------------------------------
// gcr62_sdd_if
// Request and response channel interfaces of the sector data decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcr62_sdd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] disk_byte;
   logic       field_start;

   modport source (output valid, output disk_byte, output field_start, input ready);
   modport sink   (input valid, input disk_byte, input field_start, output ready);
endinterface

interface gcr62_sdd_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] data_byte;
   logic [7:0] byte_index;
   logic [1:0] status_code;
   logic       last;

   modport source (output valid, output result_kind, output data_byte,
                   output byte_index, output status_code, output last, input ready);
   modport sink   (input valid, input result_kind, input data_byte,
                   input byte_index, input status_code, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gcr62_sdd_core.sv -----
// ----------------------------------------------------------------------------
// gcr62_sdd_core
// Field state, remainder memory and byte reconstruction, one byte per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr62_sdd_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     fire,
   input  wire logic [7:0]               disk_byte,
   input  wire logic                     field_start,
   output      logic                     has_result,
   output      gcr62_sdd_pkg::result_type result
);
   import gcr62_sdd_pkg::*;

   localparam logic [8:0] RemCount9 = 9'(RemainderCount);
   localparam logic [8:0] ChkPos9   = 9'(ChecksumPosition);
   localparam logic [6:0] LastSlot  = 7'(RemainderCount - 1);

   // position is tracked also as slot (position mod 86) and group (position / 86)
   logic [8:0] position_ff, position_in;
   logic [6:0] slot_ff, slot_in;
   logic [1:0] group_ff, group_in;
   logic [5:0] xor_ff, xor_in;
   logic       discard_ff, discard_in;
   logic [5:0] rd_ff;
   logic [5:0] rem_mem [RemainderCount];

   logic [8:0] pos;
   logic [6:0] slot;
   logic [1:0] grp;
   logic [5:0] xr;
   logic       disc;
   logic       advance;
   logic       mem_we;
   logic [1:0] lo_bits;
   logic [8:0] index_wide;
   xlate_type  tr;

   always_comb begin
      pos  = field_start ? 9'd0 : position_ff;
      slot = field_start ? 7'd0 : slot_ff;
      grp  = field_start ? 2'd0 : group_ff;
      xr   = field_start ? 6'd0 : xor_ff;
      disc = field_start ? 1'b0 : discard_ff;
      tr   = gcr_translate(disk_byte);

      index_wide = pos - RemCount9;
      case (grp)
         2'd1:    lo_bits = rd_ff[1:0];
         2'd2:    lo_bits = rd_ff[3:2];
         2'd3:    lo_bits = rd_ff[5:4];
         default: lo_bits = 2'd0;
      endcase

      xor_in     = xr;
      discard_in = disc;
      advance    = 1'b0;
      mem_we     = 1'b0;
      has_result = 1'b0;
      result     = '{result_kind: KIND_DATA, data_byte: 8'd0, byte_index: 8'd0,
                     status_code: STATUS_OK, last: 1'b0};

      if (!disc) begin
         if (!tr.valid) begin
            discard_in         = 1'b1;
            has_result         = 1'b1;
            result.result_kind = KIND_STATUS;
            result.status_code = STATUS_INVALID;
            result.last        = 1'b1;
         end else begin
            xor_in = xr ^ tr.value;
            if (grp == 2'd0) begin
               mem_we  = 1'b1;
               advance = 1'b1;
            end else if (pos != ChkPos9) begin
               advance           = 1'b1;
               has_result        = 1'b1;
               result.data_byte  = {xor_in, lo_bits};
               result.byte_index = index_wide[7:0];
            end else begin
               discard_in         = 1'b1;
               has_result         = 1'b1;
               result.result_kind = KIND_STATUS;
               result.status_code = (xor_in == 6'd0) ? STATUS_OK : STATUS_MISMATCH;
               result.last        = 1'b1;
            end
         end
      end

      position_in = pos;
      slot_in     = slot;
      group_in    = grp;
      if (advance) begin
         position_in = pos + 9'd1;
         if (slot == LastSlot) begin
            slot_in  = 7'd0;
            group_in = grp + 2'd1;
         end else begin
            slot_in = slot + 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= 9'd0;
         slot_ff     <= 7'd0;
         group_ff    <= 2'd0;
         xor_ff      <= 6'd0;
         discard_ff  <= 1'b0;
      end else if (fire) begin
         position_ff <= position_in;
         slot_ff     <= slot_in;
         group_ff    <= group_in;
         xor_ff      <= xor_in;
         discard_ff  <= discard_in;
      end
   end

   // Remainder read is fetched one byte ahead, for the slot the next byte uses.
   always_ff @(posedge clock) begin
      if (fire && mem_we) begin
         rem_mem[slot] <= xor_in;
      end
      if (fire) begin
         rd_ff <= rem_mem[slot_in];
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/gcr62_sector_data_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// gcr62_sector_data_decoder_unit
// 6-and-2 GCR sector data field decoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one raw disk byte per request, with field_start set on the
//   first byte of a data field. rsp returns a data byte with its index for
//   each of the 256 sector bytes, and one closing status (ok, invalid byte,
//   checksum mismatch) with last set. Remainder bytes give no response.
//   After a status, bytes are dropped until the next field_start.
//   A request is registered on acceptance, and its response is registered in
//   the response register when the core fires; rsp.valid rises with it.
//   Throughput: one request per cycle while rsp is not stalled; the limit is
//   the single response register.
//   When rsp.ready is low the response holds; the request register still
//   takes a request, then req.ready drops until the response leaves.
//   Reset clears both valid flags, the byte position, the running XOR and
//   the drop flag; the remainder memory is not cleared, it is always
//   rewritten before it is read within a field.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr62_sector_data_decoder_unit (
   input wire logic         clock,
   input wire logic         reset,
   gcr62_sdd_req_if.sink    req,
   gcr62_sdd_rsp_if.source  rsp
);
   import gcr62_sdd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic       fire;
   logic       has_result;
   result_type result;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = req.ready ? req.valid : in_valid_ff;
      if (fire) begin
         out_valid_in = has_result;
      end else begin
         out_valid_in = out_valid_ff && !rsp.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_byte_ff  <= req.disk_byte;
         in_start_ff <= req.field_start;
      end
      if (fire && has_result) begin
         out_ff <= result;
      end
   end

   gcr62_sdd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .disk_byte   (in_byte_ff),
      .field_start (in_start_ff),
      .has_result  (has_result),
      .result      (result)
   );

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = out_ff.result_kind;
   assign rsp.data_byte   = out_ff.data_byte;
   assign rsp.byte_index  = out_ff.byte_index;
   assign rsp.status_code = out_ff.status_code;
   assign rsp.last        = out_ff.last;

endmodule

`default_nettype wire

// ----- rtl/core/gcr62_sdd_checker.sv -----
// ----------------------------------------------------------------------------
// gcr62_sdd_checker
// Port-level assertions for the sector data decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gcr62_sector_data_decoder_unit_macros.svh"

module gcr62_sdd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_result_kind,
   input wire logic [7:0] rsp_data_byte,
   input wire logic [7:0] rsp_byte_index,
   input wire logic [1:0] rsp_status_code,
   input wire logic       rsp_last
);
   import gcr62_sdd_pkg::*;

   logic [19:0] rsp_payload;
   assign rsp_payload = {rsp_result_kind, rsp_data_byte, rsp_byte_index,
                         rsp_status_code, rsp_last};

   `GCR62_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response changed while stalled")
   `GCR62_ASSERT_SAME(a_status_shape, rsp_valid, (rsp_result_kind == rsp_last) && (rsp_result_kind || (rsp_status_code == STATUS_OK)), "response kind, last and status disagree")
   `GCR62_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid, "response valid right after reset")
   // With no response pending, only a request taken in the previous cycle can be in the input register
   `GCR62_ASSERT_NEXT(a_no_result_from_nothing, !rsp_valid && !$past(req_valid && req_ready), !rsp_valid, "response without a request")

endmodule

bind gcr62_sector_data_decoder_unit gcr62_sdd_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_result_kind (rsp.result_kind),
   .rsp_data_byte   (rsp.data_byte),
   .rsp_byte_index  (rsp.byte_index),
   .rsp_status_code (rsp.status_code),
   .rsp_last        (rsp.last)
);

`default_nettype wire

// ----- tb/gcr62_sector_decode_monitor.sv -----
// ----------------------------------------------------------------------------
// gcr62_sector_decode_monitor
// Watches the request and response channels of the 6-and-2 sector data
// decoder, decodes every accepted disk byte on its own and compares each
// response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcr62_sector_decode_monitor
   import gcr62_sdd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   gcr62_sdd_req_if req_if,
   gcr62_sdd_rsp_if rsp_if,
   output int       awaited_count,
   output int       mismatch_count
);

   localparam int SectorRemainders = 86;
   localparam int ChecksumSlot     = 342;

   localparam logic [7:0] DiskCodes [64] = '{
      8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
      8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
      8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
      8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
      8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
      8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
      8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
      8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
   };

   // bit 6 set: byte is not a legal disk code
   logic [6:0] sixbit_lut [256];

   logic [8:0] sector_pos;
   logic [5:0] chain_xor;
   logic [5:0] remainder_mem [SectorRemainders];
   logic       dropping;
   result_type awaited_results [$];

   initial begin
      for (int b = 0; b < 256; b++) sixbit_lut[b] = 7'h40;
      for (int k = 0; k < 64; k++) sixbit_lut[DiskCodes[k]] = {1'b0, 6'(k)};
      sector_pos     = '0;
      chain_xor      = '0;
      dropping       = 1'b0;
      awaited_count  = 0;
      mismatch_count = 0;
   end

   task automatic decode_disk_byte(input logic [7:0] code, input logic start);
      logic [6:0]  six;
      result_type  r;
      int unsigned i;
      six = sixbit_lut[code];
      r   = '0;
      if (start) begin
         sector_pos = '0;
         chain_xor  = '0;
         dropping   = 1'b0;
      end
      if (dropping) return;
      if (six[6]) begin
         dropping      = 1'b1;
         r.result_kind = KIND_STATUS;
         r.status_code = STATUS_INVALID;
         r.last        = 1'b1;
         awaited_results.push_back(r);
         return;
      end
      chain_xor = chain_xor ^ six[5:0];
      if (sector_pos < SectorRemainders) begin
         remainder_mem[sector_pos] = chain_xor;
         sector_pos++;
      end else if (sector_pos < ChecksumSlot) begin
         i = sector_pos - SectorRemainders;
         r.result_kind = KIND_DATA;
         r.data_byte   = {chain_xor,
            2'(remainder_mem[i % SectorRemainders] >> ((i / SectorRemainders) * 2))};
         r.byte_index  = 8'(i);
         sector_pos++;
         awaited_results.push_back(r);
      end else begin
         // checksum byte: running XOR must land on zero
         dropping      = 1'b1;
         r.result_kind = KIND_STATUS;
         r.status_code = (chain_xor == 6'd0) ? STATUS_OK : STATUS_MISMATCH;
         r.last        = 1'b1;
         awaited_results.push_back(r);
      end
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         sector_pos = '0;
         chain_xor  = '0;
         dropping   = 1'b0;
         awaited_results.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_results.size() == 0) begin
               $error("response with nothing outstanding: kind %0d data 0x%0h index %0d",
                      rsp_if.result_kind, rsp_if.data_byte, rsp_if.byte_index);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("result_kind", 8'(want.result_kind), 8'(rsp_if.result_kind));
               check_field("data_byte", want.data_byte, rsp_if.data_byte);
               check_field("byte_index", want.byte_index, rsp_if.byte_index);
               check_field("status_code", 8'(want.status_code), 8'(rsp_if.status_code));
               check_field("last", 8'(want.last), 8'(rsp_if.last));
            end
         end
         if (req_if.valid && req_if.ready)
            decode_disk_byte(req_if.disk_byte, req_if.field_start);
      end
      awaited_count <= awaited_results.size();
   end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Sector data decoder regression: directed odd bytes, then encoded sectors
// (clean, bad checksum, broken by illegal codes, cut short) and junk, under
// changing sender gaps and receiver stalls including long back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import gcr62_sdd_pkg::*;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_e;

   logic clock = 1'b0;
   logic reset;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int sent_total    = 0;
   int ignored_total = 0;
   int long_hold_seq = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int awaited_count;
   int mismatch_count;

   gcr62_sdd_req_if req_if ();
   gcr62_sdd_rsp_if rsp_if ();

   gcr62_sector_data_decoder_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   gcr62_sector_decode_monitor decode_mon (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .awaited_count  (awaited_count),
      .mismatch_count (mismatch_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // response side: random stalls, plus a long hold-off when requested
   always @(posedge clock) begin
      if (hold_seen != long_hold_seq) begin
         hold_seen    <= long_hold_seq;
         hold_left    <= 200;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [7:0] random_bad_byte();
      logic [7:0] b;
      logic       hit;
      do begin
         b   = 8'($urandom_range(255));
         hit = 1'b0;
         for (int k = 0; k < 64; k++)
            if (GcrTable[k] == b) hit = 1'b1;
      end while (hit);
      return b;
   endfunction

   task automatic send_byte(input logic [7:0] code, input logic start);
      case ((sent_total / 128) % 4)
         0: begin send_idle_pct = 0;  stall_pct <= 0;  end
         1: begin send_idle_pct = 54; stall_pct <= 0;  end
         2: begin send_idle_pct = 0;  stall_pct <= 54; end
         default: begin send_idle_pct = 29; stall_pct <= 29; end
      endcase
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid       <= 1'b0;
         req_if.disk_byte   <= 8'($urandom);
         req_if.field_start <= 1'($urandom);
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.disk_byte   <= code;
      req_if.field_start <= start;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_total++;
      if (sent_total == 300 || sent_total == 750)
         long_hold_seq <= long_hold_seq + 1;
   endtask

   // Encodes a sector as successive XOR differences; stop_at cuts the field
   // before that position, bad_at puts an illegal code there.
   task automatic send_sector(input fill_kind_e fill, input logic good_sum,
                              input int stop_at, input int bad_at);
      logic [5:0] chain;
      logic [5:0] target;
      int         noise;
      chain = '0;
      for (int k = 0; k <= 342; k++) begin
         if (k == stop_at) return;
         if (k == bad_at) begin
            send_byte(random_bad_byte(), k == 0);
            noise = $urandom_range(0, 4);
            repeat (noise) begin
               send_byte(8'($urandom), 1'b0);
               ignored_total++;
            end
            return;
         end
         if (k == 342) begin
            target = good_sum ? 6'd0 : 6'($urandom_range(1, 63));
            send_byte(GcrTable[chain ^ target], 1'b0);
         end else begin
            case (fill)
               FILL_ZERO: target = 6'd0;
               FILL_ONES: target = 6'h3F;
               default:   target = 6'($urandom);
            endcase
            send_byte(GcrTable[chain ^ target], k == 0);
            chain = target;
         end
      end
   endtask

   initial begin
      int         choice;
      int         n;
      fill_kind_e fill;
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.disk_byte   = 8'h00;
      req_if.field_start = 1'b0;
      rsp_if.ready       = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // first field without a start flag, then an illegal code
      send_byte(8'h96, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // dropped until the next start
      send_byte(8'hFF, 1'b0);
      send_byte(8'h96, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hD5, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hAA, 1'b1);
      send_byte(8'h96, 1'b1);
      send_byte(8'h97, 1'b0);
      send_byte(8'h80, 1'b0);

      send_sector(FILL_RANDOM, 1'b1, -1, -1);
      send_sector(FILL_RANDOM, 1'b0, -1, -1);

      while (sent_total - ignored_total < 900) begin
         choice = $urandom_range(99);
         case ($urandom_range(9))
            0:       fill = FILL_ZERO;
            1:       fill = FILL_ONES;
            default: fill = FILL_RANDOM;
         endcase
         if (choice < 55)
            send_sector(fill, $urandom_range(3) != 0, -1, -1);
         else if (choice < 72)
            send_sector(fill, 1'b1, -1, $urandom_range(0, 342));
         else if (choice < 85)
            send_sector(fill, 1'b1, $urandom_range(1, 341), -1);
         else begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom), $urandom_range(4) == 0);
         end
      end

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
